/* rtl/swik_pkg.sv */
// Shared types and constants for the swerve wheel inverse kinematics block.
// No dependencies; imported by swik_sqrt, swik_cordic and the top level.
`timescale 1ns / 1ps

package swik_pkg;

  // CORDIC vectoring
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = 5;

  // Angles in Q3.13
  localparam logic [15:0] HALF_PI_Q13 = 16'd12868;
  localparam logic [15:0] PI_Q13      = 16'd25736;

  // Binary angle (2^32 per turn) to Q3.13 scale, applied as (a*K + 2^47) >> 48
  localparam logic [31:0] BAM_TO_Q13 = 32'd3373259426;

  // Register indexes
  localparam logic [2:0] REG_WHEEL0_X   = 3'd0;
  localparam logic [2:0] REG_WHEEL0_Y   = 3'd1;
  localparam logic [2:0] REG_WHEEL1_X   = 3'd2;
  localparam logic [2:0] REG_WHEEL1_Y   = 3'd3;
  localparam logic [2:0] REG_INV_RADIUS = 3'd4;

  // Register reset values
  localparam logic [15:0] RST_WHEEL0_X   = 16'd1229;
  localparam logic [15:0] RST_WHEEL0_Y   = 16'hFCCD;   // -819
  localparam logic [15:0] RST_WHEEL1_X   = 16'hFB33;   // -1229
  localparam logic [15:0] RST_WHEEL1_Y   = 16'd819;
  localparam logic [15:0] RST_INV_RADIUS = 16'd2560;

  // Control for the iterative units
  typedef struct packed {
    logic load;
    logic step;
  } swik_ctl_t;

  // atan(2^-i) in binary angle units
  function automatic logic [29:0] atan_bam(input logic [STEP_W-1:0] i);
    logic [29:0] v;
    v = '0;
    unique case (i)
      5'd0:    v = 30'h20000000;
      5'd1:    v = 30'h12E4051E;
      5'd2:    v = 30'h09FB385B;
      5'd3:    v = 30'h051111D4;
      5'd4:    v = 30'h028B0D43;
      5'd5:    v = 30'h0145D7E1;
      5'd6:    v = 30'h00A2F61E;
      5'd7:    v = 30'h00517C55;
      5'd8:    v = 30'h0028BE53;
      5'd9:    v = 30'h00145F2F;
      5'd10:   v = 30'h000A2F98;
      5'd11:   v = 30'h000517CC;
      5'd12:   v = 30'h00028BE6;
      5'd13:   v = 30'h000145F3;
      5'd14:   v = 30'h0000A2FA;
      5'd15:   v = 30'h0000517D;
      5'd16:   v = 30'h000028BE;
      5'd17:   v = 30'h0000145F;
      5'd18:   v = 30'h00000A30;
      5'd19:   v = 30'h00000518;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/swik_sqrt.sv */
// Bit-serial integer square root: one result bit per step, 32 steps.
// Depends on swik_pkg.
`timescale 1ns / 1ps

module swik_sqrt (
  input  logic                clk,
  input  swik_pkg::swik_ctl_t ctl,
  input  logic [62:0]         radicand,
  output logic [31:0]         root
);
  import swik_pkg::*;

  logic [63:0] rad;     // radicand, two bits leave at the top per step
  logic [35:0] rem;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        fits;

  assign rem_sh = {rem[33:0], rad[63:62]};
  assign trial  = {2'b00, root, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rad  <= {1'b0, radicand};
      rem  <= '0;
      root <= '0;
    end else if (ctl.step) begin
      rad <= {rad[61:0], 2'b00};
      if (fits) begin
        rem  <= rem_sh - trial;
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[30:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/swik_cordic.sv */
// CORDIC vectoring unit: heading of (ux, uy), one micro-rotation per step while idx
// is below CORDIC_STEPS, result scaled to Q3.13. Depends on swik_pkg.
`timescale 1ns / 1ps

module swik_cordic (
  input  logic                   clk,
  input  swik_pkg::swik_ctl_t    ctl,
  input  logic [4:0]             idx,
  input  logic signed [31:0]     ux,
  input  logic signed [31:0]     uy,
  output logic signed [15:0]     angle
);
  import swik_pkg::*;

  logic signed [34:0] x;
  logic signed [34:0] y;
  logic signed [33:0] acc;     // binary angle, 2^32 per turn
  logic               zero;
  logic [63:0]        angprod;

  logic signed [34:0] uxe;
  logic signed [34:0] uye;
  logic signed [34:0] xs;
  logic signed [34:0] ys;
  logic signed [33:0] bam;
  logic               active;
  logic [33:0]        abs_acc;
  logic [31:0]        mag;
  logic [63:0]        rounded;
  logic [15:0]        q;
  logic [15:0]        qc;

  assign uxe    = 35'(ux);
  assign uye    = 35'(uy);
  assign xs     = x >>> idx;
  assign ys     = y >>> idx;
  assign bam    = $signed({4'b0000, atan_bam(idx)});
  assign active = ctl.step && (idx < 5'(CORDIC_STEPS));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      zero <= (ux == '0) && (uy == '0);
      if (ux[31]) begin
        // left half plane: pre-rotate by pi toward the sign of uy
        x   <= -uxe;
        y   <= -uye;
        acc <= uy[31] ? -34'sh0_8000_0000 : 34'sh0_8000_0000;
      end else begin
        x   <= uxe;
        y   <= uye;
        acc <= '0;
      end
    end else if (active) begin
      if (!y[34]) begin
        x   <= x + ys;
        y   <= y - xs;
        acc <= acc + bam;
      end else begin
        x   <= x - ys;
        y   <= y + xs;
        acc <= acc - bam;
      end
    end
    angprod <= 64'(mag) * 64'(BAM_TO_Q13);
  end

  assign abs_acc = acc[33] ? 34'(-acc) : 34'(acc);
  assign mag     = (abs_acc > 34'h0_8000_0000) ? 32'h8000_0000 : abs_acc[31:0];
  assign rounded = angprod + 64'h0000_8000_0000_0000;
  assign q       = rounded[63:48];
  assign qc      = (q > PI_Q13) ? PI_Q13 : q;

  always_comb begin
    if (zero)         angle = '0;
    else if (acc[33]) angle = $signed(16'(-qc));
    else              angle = $signed(qc);
  end

endmodule

/* rtl/swerve_wheel_inverse_kinematics.sv */
// Commands: cmd_stall holds off a new command until every wheel of the current one has
//   passed the 32-step bit-serial square root and the 16-step serial speed product
//   and been written to the result register.
// Reset (rst, synchronous, active high): sequencer idle, no result pending,
//   held headings zero, wheel geometry and inverse radius back to defaults.
// Depends on swik_pkg, swik_sqrt, swik_cordic.
`timescale 1ns / 1ps

module swerve_wheel_inverse_kinematics #(
  parameter int WHEEL_COUNT = 2
) (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic signed [15:0] body_vx,
  input  logic signed [15:0] body_vy,
  input  logic signed [15:0] body_wz,
  // configuration
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // result channel
  output logic               res_valid,
  input  logic               res_stall,
  output logic               wheel_index,
  output logic signed [15:0] steer_angle,
  output logic signed [15:0] wheel_speed,
  output logic               last_wheel
);
  import swik_pkg::*;

  // Only two wheel positions exist in the register map.
  localparam int WHEELS = (WHEEL_COUNT > 2) ? 2 : ((WHEEL_COUNT < 1) ? 1 : WHEEL_COUNT);
  localparam logic LAST_WHEEL = 1'(WHEELS - 1);

  // Sequencer: per wheel MUL0, MUL1 (wheel velocity), SQ0, SQ1 (squares, unit loads),
  // RUN (32 root bits, CORDIC in the first 20), SPD (16 product bits), FIN (output).
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL0 = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_SQ0  = 3'd3;
  localparam logic [2:0] S_SQ1  = 3'd4;
  localparam logic [2:0] S_RUN  = 3'd5;
  localparam logic [2:0] S_SPD  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [4:0] cnt;
  logic       wheel;

  // configuration registers
  logic signed [15:0] wheel0_x;
  logic signed [15:0] wheel0_y;
  logic signed [15:0] wheel1_x;
  logic signed [15:0] wheel1_y;
  logic [15:0]        inv_wheel_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel0_x         <= RST_WHEEL0_X;
      wheel0_y         <= RST_WHEEL0_Y;
      wheel1_x         <= RST_WHEEL1_X;
      wheel1_y         <= RST_WHEEL1_Y;
      inv_wheel_radius <= RST_INV_RADIUS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WHEEL0_X:   wheel0_x         <= cfg_data;
        REG_WHEEL0_Y:   wheel0_y         <= cfg_data;
        REG_WHEEL1_X:   wheel1_x         <= cfg_data;
        REG_WHEEL1_Y:   wheel1_y         <= cfg_data;
        REG_INV_RADIUS: inv_wheel_radius <= cfg_data;
        default: ;      // unmapped index, dropped
      endcase
    end
  end

  // latched command
  logic signed [15:0] vx;
  logic signed [15:0] vy;
  logic signed [15:0] wz;

  // wheel velocity ux = vx - wz*py, uy = vy + wz*px, both Q.24; one shared 16x16 multiply
  logic signed [15:0] px;
  logic signed [15:0] py;
  logic signed [15:0] mul_b;
  logic signed [31:0] wprod;
  logic signed [31:0] ux;
  logic signed [31:0] uy;

  assign px    = wheel ? wheel1_x : wheel0_x;
  assign py    = wheel ? wheel1_y : wheel0_y;
  assign mul_b = (state == S_MUL0) ? py : px;
  assign wprod = 32'(wz) * 32'(mul_b);

  // |u|^2 with one shared squarer; |ux|, |uy| stay below 2^31
  logic [31:0] abs_ux;
  logic [31:0] abs_uy;
  logic [30:0] sq_in;
  logic [61:0] sq;
  logic [61:0] sqx;
  logic [62:0] radicand;

  assign abs_ux   = ux[31] ? 32'(-ux) : 32'(ux);
  assign abs_uy   = uy[31] ? 32'(-uy) : 32'(uy);
  assign sq_in    = (state == S_SQ0) ? abs_ux[30:0] : abs_uy[30:0];
  assign sq       = 62'(sq_in) * 62'(sq_in);
  assign radicand = 63'(sqx) + 63'(sq);

  // iterative units
  swik_ctl_t          sqrt_ctl;
  swik_ctl_t          cordic_ctl;
  logic [31:0]        mag;
  logic signed [15:0] heading;

  assign sqrt_ctl.load   = (state == S_SQ1);
  assign sqrt_ctl.step   = (state == S_RUN);
  assign cordic_ctl.load = (state == S_SQ0);
  assign cordic_ctl.step = (state == S_RUN);

  swik_sqrt u_sqrt (
    .clk      (clk),
    .ctl      (sqrt_ctl),
    .radicand (radicand),
    .root     (mag)
  );

  swik_cordic u_cordic (
    .clk   (clk),
    .ctl   (cordic_ctl),
    .idx   (cnt),
    .ux    (ux),
    .uy    (uy),
    .angle (heading)
  );

  // speed product mag * inv_wheel_radius, LSB first, one multiplier bit per cycle
  logic [31:0] prod_hi;
  logic [15:0] prod_lo;
  logic [15:0] rad_sh;
  logic [32:0] psum;

  assign psum = {1'b0, prod_hi} + (rad_sh[0] ? {1'b0, mag} : 33'd0);

  // finish: rounding, heading hold / flip, saturation
  logic signed [15:0] held_heading [2];
  logic [48:0]        rounded;
  logic [24:0]        spd;
  logic signed [16:0] diff;
  logic [16:0]        abs_diff;
  logic               flip;
  logic signed [15:0] steer;
  logic [15:0]        speed;
  logic               can_write;

  assign rounded  = 49'({prod_hi, prod_lo}) + 49'h0_0000_0080_0000;
  assign spd      = rounded[48:24];
  assign diff     = 17'(heading) - 17'(held_heading[wheel]);
  assign abs_diff = diff[16] ? 17'(-diff) : 17'(diff);
  assign flip     = (abs_diff > 17'(HALF_PI_Q13));
  assign steer    = flip ? held_heading[wheel] : heading;

  always_comb begin
    if (flip) speed = (spd > 25'd32768) ? 16'h8000 : 16'(-spd);
    else      speed = (spd > 25'd32767) ? 16'h7FFF : spd[15:0];
  end

  // output register parts the result channel from the sequencer
  assign can_write = !res_valid || !res_stall;
  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (cmd_valid) state_next = S_MUL0;
      S_MUL0:  state_next = S_MUL1;
      S_MUL1:  state_next = S_SQ0;
      S_SQ0:   state_next = S_SQ1;
      S_SQ1:   state_next = S_RUN;
      S_RUN:   if (cnt == 5'd31) state_next = S_SPD;
      S_SPD:   if (cnt == 5'd15) state_next = S_FIN;
      S_FIN:   if (can_write) state_next = (wheel == LAST_WHEEL) ? S_IDLE : S_MUL0;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      cnt             <= '0;
      wheel           <= 1'b0;
      res_valid       <= 1'b0;
      held_heading[0] <= '0;
      held_heading[1] <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) cnt <= '0;
      else                     cnt <= cnt + 5'd1;

      if (state == S_IDLE && cmd_valid) wheel <= 1'b0;

      if (state == S_FIN && can_write) begin
        res_valid           <= 1'b1;
        held_heading[wheel] <= steer;
        if (wheel != LAST_WHEEL) wheel <= wheel + 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      vx <= body_vx;
      vy <= body_vy;
      wz <= body_wz;
    end
    if (state == S_MUL0) ux <= 32'($signed({vx, 12'd0})) - wprod;
    if (state == S_MUL1) uy <= 32'($signed({vy, 12'd0})) + wprod;
    if (state == S_SQ0)  sqx <= sq;
    if (state == S_RUN) begin
      prod_hi <= '0;
      prod_lo <= '0;
      rad_sh  <= inv_wheel_radius;
    end else if (state == S_SPD) begin
      prod_hi <= psum[32:1];
      prod_lo <= {psum[0], prod_lo[15:1]};
      rad_sh  <= {1'b0, rad_sh[15:1]};
    end
    if (state == S_FIN && can_write) begin
      wheel_index <= wheel;
      steer_angle <= steer;
      wheel_speed <= speed;
      last_wheel  <= (wheel == LAST_WHEEL);
    end
  end

endmodule

/* rtl/swik_check.sv */
// Port-level checks for swerve_wheel_inverse_kinematics, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module swik_check #(
  parameter int WHEEL_COUNT = 2
) (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_stall,
  input logic               res_valid,
  input logic               res_stall,
  input logic               wheel_index,
  input logic signed [15:0] steer_angle,
  input logic signed [15:0] wheel_speed,
  input logic               last_wheel
);

  localparam int WHEELS = (WHEEL_COUNT > 2) ? 2 : ((WHEEL_COUNT < 1) ? 1 : WHEEL_COUNT);
  localparam logic LAST_IDX = 1'(WHEELS - 1);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(wheel_index) && $stable(steer_angle)
      && $stable(wheel_speed) && $stable(last_wheel))
    else $error("stalled result beat changed");

  a_steer_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (steer_angle <= 16'sd25736) && (steer_angle >= -16'sd25736))
    else $error("steer angle beyond +-pi");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (last_wheel == (wheel_index == LAST_IDX)))
    else $error("last_wheel does not match wheel_index");

  a_busy_mid_cmd: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last_wheel |-> cmd_stall)
    else $error("command taken before all wheels of the previous one");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("not busy after command beat");

endmodule

bind swerve_wheel_inverse_kinematics swik_check #(.WHEEL_COUNT(WHEEL_COUNT)) u_swik_check (.*);
